### src/cpt4_pkg.sv
`default_nettype none
package cpt4_pkg;

    localparam int COORD_W = 32;
    localparam int BASIS_W = 16;
    localparam int BASIS_FRAC = BASIS_W - 2;
    localparam int TRIG_W = 16;
    localparam int TRIG_FRAC = 14;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + BASIS_W;
    localparam int ACC_W = PROD_W + 2;
    localparam int QDEPTH = 2;

    localparam logic [1:0] OP_TRANSFORM = 2'd0;
    localparam logic [1:0] OP_ROTATE    = 2'd1;
    localparam logic [1:0] OP_MOVE      = 2'd2;
    localparam logic [1:0] OP_NONE      = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [BASIS_W-1:0] basis_t;

    typedef struct packed {
        logic [1:0]                operation;
        logic [2:0]                plane;
        logic [1:0]                axis;
        logic signed [TRIG_W-1:0]  cos_value;
        logic signed [TRIG_W-1:0]  sin_value;
        logic signed [31:0]        distance;
        logic signed [31:0]        point_w;
        logic signed [31:0]        point_x;
        logic signed [31:0]        point_y;
        logic signed [31:0]        point_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] view_w;
        logic signed [31:0] view_x;
        logic signed [31:0] view_y;
        logic signed [31:0] view_z;
    } out_word_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [1:0]               op;
        logic [1:0]               col_a;
        logic [1:0]               col_b;
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W:0]   s;
        logic [1:0]               axis;
        logic signed [31:0]       distance;
        logic signed [31:0]       pw;
        logic signed [31:0]       px;
        logic signed [31:0]       py;
        logic signed [31:0]       pz;
    } cmd_t;

    function automatic logic [1:0] plane_a(input logic [2:0] p);
        case (p)
            3'd1, 3'd5: plane_a = 2'd1;
            3'd2:       plane_a = 2'd2;
            default:    plane_a = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] plane_b(input logic [2:0] p);
        case (p)
            3'd0:       plane_b = 2'd1;
            3'd1, 3'd4: plane_b = 2'd2;
            default:    plane_b = 2'd3;
        endcase
    endfunction

endpackage
`default_nettype wire

### src/camera_pose_transform_4d.sv
// channel | valid     | ready     | payload
// in      | in_valid  | in_ready  | in_data  (cpt4_pkg::in_word_t)
// out     | out_valid | out_ready | out_data (cpt4_pkg::out_word_t)
// one word per cycle while in_ready is high; a transform's result passes through the
// queue, difference, product, and sum/round/saturate into the output register
// rotate and move update the pose as they leave the queue
// reset sets the basis to identity and the position to zero
// a stalled output holds the pipeline; the two-entry queue then fills and drops ready
`default_nettype none
module camera_pose_transform_4d (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire cpt4_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output cpt4_pkg::out_word_t     out_data
);
    logic           cmd_valid, cmd_ready;
    cpt4_pkg::cmd_t cmd_data;

    cpt4_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data)
    );

    cpt4_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("queued command lost");
endmodule
`default_nettype wire

### src/cpt4_front.sv
`default_nettype none
module cpt4_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire cpt4_pkg::in_word_t in_data,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output cpt4_pkg::cmd_t        cmd_data
);
    // two-entry queue
    cpt4_pkg::cmd_t q_reg [cpt4_pkg::QDEPTH];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    cpt4_pkg::cmd_t cmd;
    logic       drop, push, pop;

    always_comb
    begin
        cmd = '0;
        cmd.op = in_data.operation;
        cmd.col_a = cpt4_pkg::plane_a(in_data.plane);
        cmd.col_b = cpt4_pkg::plane_b(in_data.plane);
        cmd.c = in_data.cos_value;
        cmd.s = (in_data.plane == 3'd3) ? -{in_data.sin_value[15], in_data.sin_value}
                                        : {in_data.sin_value[15], in_data.sin_value};
        cmd.axis = in_data.axis;
        cmd.distance = in_data.distance;
        cmd.pw = in_data.point_w;
        cmd.px = in_data.point_x;
        cmd.py = in_data.point_y;
        cmd.pz = in_data.point_z;
        // no-ops, and rotates with a plane above 5, are dropped here
        drop = (in_data.operation == cpt4_pkg::OP_NONE) ||
               (in_data.operation == cpt4_pkg::OP_ROTATE && in_data.plane > 3'd5);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_data  = q_reg[rp_reg];
    assign push = in_valid && in_ready && !drop;
    assign pop  = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= cmd;
    end
endmodule
`default_nettype wire

### src/cpt4_back.sv
`default_nettype none
module cpt4_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_ready,
    input  wire cpt4_pkg::cmd_t   cmd_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output cpt4_pkg::out_word_t   out_data
);
    localparam int CW = cpt4_pkg::COORD_W;
    localparam int BW = cpt4_pkg::BASIS_W;
    localparam int DW = cpt4_pkg::DIFF_W;
    localparam int PW = cpt4_pkg::PROD_W;
    localparam int AW = cpt4_pkg::ACC_W;
    localparam int RW = BW + cpt4_pkg::TRIG_W + 3;
    localparam int MW = CW + BW;
    localparam logic signed [AW-1:0] C_MAX = AW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] C_MIN = -C_MAX - AW'(1);

    cpt4_pkg::basis_t b_reg [16];
    cpt4_pkg::coord_t pos_reg [4];

    // stage 1: differences; stage 2: products; stage 3: sums and output
    logic s1_v_reg, s2_v_reg, o_v_reg;
    logic signed [DW-1:0] d_reg [4];
    cpt4_pkg::basis_t     bt_reg [16];
    logic signed [PW-1:0] p_reg [16];
    cpt4_pkg::out_word_t  o_reg;
    logic signed [CW-1:0] res [4];
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] rnd;
    logic stall;

    function automatic logic signed [BW-1:0] sat_b(input logic signed [RW-1:0] v);
        logic signed [RW-1:0] r;
        r = (v + (RW'(1) <<< (cpt4_pkg::TRIG_FRAC - 1))) >>> cpt4_pkg::TRIG_FRAC;
        if (r > RW'((1 <<< (BW - 1)) - 1))
            sat_b = {1'b0, {(BW-1){1'b1}}};
        else if (r < -RW'(1 <<< (BW - 1)))
            sat_b = {1'b1, {(BW-1){1'b0}}};
        else
            sat_b = r[BW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] sat_c(input logic signed [AW-1:0] v);
        if (v > C_MAX)
            sat_c = {1'b0, {(CW-1){1'b1}}};
        else if (v < C_MIN)
            sat_c = {1'b1, {(CW-1){1'b0}}};
        else
            sat_c = v[CW-1:0];
    endfunction

    // updates are applied in the issue cycle; transforms snapshot state then
    assign stall = o_v_reg && !out_ready && s2_v_reg;
    assign cmd_ready = !(stall && s1_v_reg);
    wire issue = cmd_valid && cmd_ready;

    // pose update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                b_reg[i] <= (i % 5 == 0) ? BW'(1 <<< cpt4_pkg::BASIS_FRAC) : '0;
            for (int i = 0; i < 4; i++)
                pos_reg[i] <= '0;
        end
        else if (issue && cmd_data.op == cpt4_pkg::OP_ROTATE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                b_reg[i*4 + cmd_data.col_a] <= sat_b(
                    RW'(cmd_data.c * b_reg[i*4 + cmd_data.col_a]) +
                    RW'(cmd_data.s * b_reg[i*4 + cmd_data.col_b]));
                b_reg[i*4 + cmd_data.col_b] <= sat_b(
                    RW'(cmd_data.c * b_reg[i*4 + cmd_data.col_b]) -
                    RW'(cmd_data.s * b_reg[i*4 + cmd_data.col_a]));
            end
        end
        else if (issue && cmd_data.op == cpt4_pkg::OP_MOVE)
        begin
            for (int i = 0; i < 4; i++)
            begin
                logic signed [MW-1:0] m;
                logic signed [MW-1:0] st;
                logic signed [AW-1:0] sm;
                m = MW'(cmd_data.distance) * MW'(b_reg[i*4 + cmd_data.axis]);
                st = (m + (MW'(1) <<< (cpt4_pkg::BASIS_FRAC - 1))) >>> cpt4_pkg::BASIS_FRAC;
                sm = AW'(pos_reg[i]) + AW'(st);
                pos_reg[i] <= sat_c(sm);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (!stall || !s1_v_reg)
                s1_v_reg <= issue && cmd_data.op == cpt4_pkg::OP_TRANSFORM;
            if (!stall)
                s2_v_reg <= s1_v_reg;
            if (!o_v_reg || out_ready)
                o_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            d_reg[0] <= DW'(cmd_data.pw) - DW'(pos_reg[0]);
            d_reg[1] <= DW'(cmd_data.px) - DW'(pos_reg[1]);
            d_reg[2] <= DW'(cmd_data.py) - DW'(pos_reg[2]);
            d_reg[3] <= DW'(cmd_data.pz) - DW'(pos_reg[3]);
            for (int k = 0; k < 16; k++)
                bt_reg[k] <= b_reg[k];
        end
        if (!stall)
            for (int j = 0; j < 4; j++)
                for (int i = 0; i < 4; i++)
                    p_reg[j*4 + i] <= PW'(d_reg[j]) * PW'(bt_reg[j*4 + i]);
        if (!o_v_reg || out_ready)
        begin
            o_reg.view_w <= res[0];
            o_reg.view_x <= res[1];
            o_reg.view_y <= res[2];
            o_reg.view_z <= res[3];
        end
    end

    always_comb
    begin
        acc = '0;
        rnd = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = AW'(p_reg[i]) + AW'(p_reg[4 + i]) + AW'(p_reg[8 + i]) + AW'(p_reg[12 + i]);
            rnd = (acc + (AW'(1) <<< (cpt4_pkg::BASIS_FRAC - 1))) >>> cpt4_pkg::BASIS_FRAC;
            res[i] = sat_c(rnd);
        end
    end

    assign out_valid = o_v_reg;
    assign out_data  = o_reg;
endmodule
`default_nettype wire

### tb/camera_pose_checker.sv
`timescale 1ns / 1ps
module camera_pose_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_ready,
    input  wire cpt4_pkg::in_word_t  in_data,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire cpt4_pkg::out_word_t out_data,
    output int                       fail_count,
    output int                       pending_views
);

    logic signed [63:0]  basis [16];
    logic signed [63:0]  position [4];
    cpt4_pkg::out_word_t view_queue [$];

    function automatic logic signed [63:0] round_sat(input logic signed [63:0] acc,
                                                     input int shift, input int width);
        logic signed [63:0] v;
        logic signed [63:0] hi;
        v  = (acc + (64'sd1 <<< (shift - 1))) >>> shift;
        hi = (64'sd1 <<< (width - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic signed [63:0] sat_to(input logic signed [63:0] v, input int width);
        logic signed [63:0] hi;
        hi = (64'sd1 <<< (width - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    task automatic reset_pose();
        for (int i = 0; i < 16; i++)
            basis[i] = (i % 5 == 0) ? (64'sd1 <<< cpt4_pkg::BASIS_FRAC) : 64'sd0;
        for (int i = 0; i < 4; i++)
            position[i] = 0;
    endtask

    task automatic apply_word(input cpt4_pkg::in_word_t w);
        logic signed [63:0] diff [4];
        logic signed [63:0] acc;
        logic signed [63:0] c, s, va, vb, d;
        logic signed [63:0] res [4];
        int a, b;
        cpt4_pkg::out_word_t v;
        case (w.operation)
            cpt4_pkg::OP_TRANSFORM:
            begin
                diff[0] = w.point_w - position[0];
                diff[1] = w.point_x - position[1];
                diff[2] = w.point_y - position[2];
                diff[3] = w.point_z - position[3];
                for (int i = 0; i < 4; i++)
                begin
                    acc = 0;
                    for (int j = 0; j < 4; j++)
                        acc += basis[j*4+i] * diff[j];
                    res[i] = round_sat(acc, cpt4_pkg::BASIS_FRAC, cpt4_pkg::COORD_W);
                end
                v.view_w = res[0][31:0];
                v.view_x = res[1][31:0];
                v.view_y = res[2][31:0];
                v.view_z = res[3][31:0];
                view_queue.push_back(v);
            end
            cpt4_pkg::OP_ROTATE:
            begin
                if (w.plane <= 3'd5)
                begin
                    case (w.plane)
                        3'd0: begin a = 0; b = 1; end
                        3'd1: begin a = 1; b = 2; end
                        3'd2: begin a = 2; b = 3; end
                        3'd3: begin a = 0; b = 3; end
                        3'd4: begin a = 0; b = 2; end
                        default: begin a = 1; b = 3; end
                    endcase
                    c = w.cos_value;
                    s = w.sin_value;
                    // the wz plane turns the other way
                    if (w.plane == 3'd3) s = -s;
                    for (int i = 0; i < 4; i++)
                    begin
                        va = basis[i*4+a];
                        vb = basis[i*4+b];
                        basis[i*4+a] = round_sat(c*va + s*vb, cpt4_pkg::TRIG_FRAC,
                                                 cpt4_pkg::BASIS_W);
                        basis[i*4+b] = round_sat(c*vb - s*va, cpt4_pkg::TRIG_FRAC,
                                                 cpt4_pkg::BASIS_W);
                    end
                end
            end
            cpt4_pkg::OP_MOVE:
            begin
                d = w.distance;
                for (int i = 0; i < 4; i++)
                    position[i] = sat_to(position[i]
                        + round_sat(d * basis[i*4+w.axis], cpt4_pkg::BASIS_FRAC, 64),
                        cpt4_pkg::COORD_W);
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        cpt4_pkg::out_word_t want;
        if (!rst_n)
        begin
            reset_pose();
            view_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (view_queue.size() == 0)
                    report("unexpected view_w", out_data.view_w, 32'h0);
                else
                begin
                    want = view_queue.pop_front();
                    if (out_data.view_w !== want.view_w)
                        report("view_w", out_data.view_w, want.view_w);
                    if (out_data.view_x !== want.view_x)
                        report("view_x", out_data.view_x, want.view_x);
                    if (out_data.view_y !== want.view_y)
                        report("view_y", out_data.view_y, want.view_y);
                    if (out_data.view_z !== want.view_z)
                        report("view_z", out_data.view_z, want.view_z);
                end
            end
            if (in_valid && in_ready)
                apply_word(in_data);
        end
        pending_views <= view_queue.size();
    end

endmodule

### tb/camera_pose_transform_4d_tb.sv
`timescale 1ns / 1ps
module camera_pose_transform_4d_tb;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    cpt4_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_ready;
    cpt4_pkg::out_word_t out_data;
    int                  fail_count;
    int                  pending_views;
    int                  cycle_count;
    logic                hold_off;

    localparam int CYCLE_LIMIT = 400000;

    camera_pose_transform_4d DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    camera_pose_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending_views(pending_views)
    );

    initial clk = 0;
    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 8) << 16;
            3: return -($urandom_range(0, 8) << 16);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_trig();
        case ($urandom_range(0, 5))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'd0;
            3: return 16'($urandom);
            default: return 16'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic cpt4_pkg::in_word_t make_word(input logic [1:0] op);
        cpt4_pkg::in_word_t w;
        w.operation = op;
        w.plane     = 3'($urandom);
        w.axis      = 2'($urandom);
        w.cos_value = rand_trig();
        w.sin_value = rand_trig();
        w.distance  = rand_coord();
        w.point_w   = rand_coord();
        w.point_x   = rand_coord();
        w.point_y   = rand_coord();
        w.point_z   = rand_coord();
        return w;
    endfunction

    // hold valid until accepted
    task automatic send(input cpt4_pkg::in_word_t w);
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
    endtask

    // receiver stalls, with one long hold-off early on
    initial
    begin
        out_ready = 1'b0;
        hold_off  = 1'b0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        hold_off <= 1'b1;
        out_ready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
        while (1)
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if ($urandom_range(0, 2) != 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
    end

    initial
    begin
        cpt4_pkg::in_word_t w;
        int burst;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity transform, every plane, every axis, extremes
        w = make_word(cpt4_pkg::OP_TRANSFORM);
        w.point_w = 32'h7fffffff; w.point_x = 32'h80000000;
        w.point_y = 0; w.point_z = 32'hffffffff;
        send(w);
        for (int p = 0; p < 8; p++)
        begin
            w = make_word(cpt4_pkg::OP_ROTATE);
            w.plane = 3'(p);
            w.cos_value = (p % 2) ? 16'sd11585 : -16'sd16384;
            w.sin_value = (p % 2) ? -16'sd11585 : 16'sd16384;
            send(w);
            send(make_word(cpt4_pkg::OP_TRANSFORM));
        end
        for (int a = 0; a < 4; a++)
        begin
            w = make_word(cpt4_pkg::OP_MOVE);
            w.axis = 2'(a);
            w.distance = (a % 2) ? 32'h7fffffff : 32'h80000000;
            send(w);
        end
        send(make_word(cpt4_pkg::OP_NONE));
        w = make_word(cpt4_pkg::OP_TRANSFORM);
        w.point_w = 32'h80000000; w.point_x = 32'h7fffffff;
        w.point_y = 32'h80000000; w.point_z = 32'h7fffffff;
        send(w);

        // random: mostly transforms, occasional pose updates
        for (int n = 0; n < 1500; n += burst)
        begin
            burst = $urandom_range(1, 30);
            for (int k = 0; k < burst; k++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: w = make_word(cpt4_pkg::OP_ROTATE);
                    3, 4:    w = make_word(cpt4_pkg::OP_MOVE);
                    5:       w = make_word(cpt4_pkg::OP_NONE);
                    default: w = make_word(cpt4_pkg::OP_TRANSFORM);
                endcase
                send(w);
            end
            if ($urandom_range(0, 3) != 0 && !hold_off)
                pause_sender();
        end
        in_valid <= 1'b0;

        while (pending_views != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
